>>> rtl/core/cpfir_pkg.sv
// package for the complex fir filter core: widths, item codes and shared types
// no dependencies
package cpfir_pkg;

    localparam int DATA_W    = 16;
    localparam int IDX_W     = 6;
    localparam int TAPS_DEF  = 64;
    localparam int LOAD_SPAN = 64;

    // item codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    // contents of one cell: delay line sample and its paired coefficient
    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic signed [DATA_W-1:0] coef;
    } cell_data_t;

    // control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear_h;
    } cell_ctrl_t;

endpackage

>>> rtl/core/cpfir_cell.sv
// one cell of the tap chain: holds one complex delay sample and one coefficient
// depends on cpfir_pkg
module cpfir_cell import cpfir_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_ctrl_t               ctrl,
    input  logic                     load_en,
    input  logic signed [DATA_W-1:0] coef_value,
    input  cell_data_t               prev,
    output cell_data_t               cur
);

    cell_data_t cell_reg;
    cell_data_t cell_next;

    // rotate moves sample and coefficient, shift moves the sample only
    always_comb begin
        cell_next = cell_reg;
        if (ctrl.rotate) begin
            cell_next = prev;
        end else if (ctrl.shift) begin
            cell_next.re = prev.re;
            cell_next.im = prev.im;
        end
        if (load_en) begin
            cell_next.coef = coef_value;
        end
        if (ctrl.clear_h) begin
            cell_next.re = '0;
            cell_next.im = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cur = cell_reg;

endmodule

>>> rtl/core/cpfir_mac.sv
// multiply-accumulate at the end of the tap chain, with rounding and saturation
// depends on cpfir_pkg
module cpfir_mac import cpfir_pkg::*; #(
    parameter int ACC_W = 2 * DATA_W + 2 + $clog2(TAPS_DEF)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     acc_clr,
    input  logic                     tap_vld,
    input  cell_data_t               tap,
    output logic signed [DATA_W-1:0] result_re,
    output logic signed [DATA_W-1:0] result_im,
    output logic                     saturated
);

    localparam int PROD_W = 2 * DATA_W;
    localparam int SH_W   = ACC_W - (DATA_W - 1);
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (DATA_W - 2);
    localparam logic signed [SH_W-1:0]  MAX_V = SH_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [SH_W-1:0]  MIN_V = -SH_W'(1 << (DATA_W - 1));

    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_reg, acc_im_next;
    logic signed [ACC_W-1:0]  rnd_re, rnd_im;
    logic signed [SH_W-1:0]   sh_re, sh_im;
    logic                     sat_re, sat_im;

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= tap_vld;
        end
        prod_re_reg <= tap.re * tap.coef;
        prod_im_reg <= tap.im * tap.coef;
    end

    // accumulate stage
    always_comb begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (acc_clr) begin
            acc_re_next = '0;
            acc_im_next = '0;
        end else if (prod_vld_reg) begin
            acc_re_next = acc_re_reg + {{(ACC_W-PROD_W){prod_re_reg[PROD_W-1]}}, prod_re_reg};
            acc_im_next = acc_im_reg + {{(ACC_W-PROD_W){prod_im_reg[PROD_W-1]}}, prod_im_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    // round half up back to q1.15, then clip
    always_comb begin
        rnd_re = acc_re_reg + HALF;
        rnd_im = acc_im_reg + HALF;
        sh_re  = rnd_re[ACC_W-1:DATA_W-1];
        sh_im  = rnd_im[ACC_W-1:DATA_W-1];
        sat_re = (sh_re > MAX_V) || (sh_re < MIN_V);
        sat_im = (sh_im > MAX_V) || (sh_im < MIN_V);
        if (sh_re > MAX_V) begin
            result_re = MAX_V[DATA_W-1:0];
        end else if (sh_re < MIN_V) begin
            result_re = MIN_V[DATA_W-1:0];
        end else begin
            result_re = sh_re[DATA_W-1:0];
        end
        if (sh_im > MAX_V) begin
            result_im = MAX_V[DATA_W-1:0];
        end else if (sh_im < MIN_V) begin
            result_im = MIN_V[DATA_W-1:0];
        end else begin
            result_im = sh_im[DATA_W-1:0];
        end
        saturated = sat_re || sat_im;
    end

endmodule

>>> rtl/core/complex_fir_filter_core.sv
// complex fir filter core: a load item writes one coefficient.
// a filter item shifts its sample in, then the tap chain rotates TAPS times past one
// complex mac; after a flush state the result moves into the output register, and s_ready
// stays low until then, so no new item is taken while a filter item is in progress.
// synchronous active-low reset clears the delay line, the coefficients and all control.
// depends on cpfir_pkg, cpfir_cell and cpfir_mac
module complex_fir_filter_core import cpfir_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [IDX_W-1:0]         s_coef_index,
    input  logic signed [DATA_W-1:0] s_coef_value,
    input  logic signed [DATA_W-1:0] s_sample_re,
    input  logic signed [DATA_W-1:0] s_sample_im,
    input  logic                     s_last_of_block,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_result_re,
    output logic signed [DATA_W-1:0] m_result_im,
    output logic                     m_saturated
);

    localparam int CNT_W = $clog2(TAPS);
    localparam int ACC_W = 2 * DATA_W + 2 + $clog2(TAPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] res_re_reg, res_im_reg;
    logic             sat_reg;

    logic             take_filter, take_load, out_load;
    cell_ctrl_t       ctrl;
    cell_data_t       chain [TAPS];
    cell_data_t       head;
    logic signed [DATA_W-1:0] mac_re, mac_im;
    logic             mac_sat;

    assign s_ready     = (state_reg == ST_IDLE);
    assign take_filter = s_valid && s_ready && (s_cmd == CMD_FILTER);
    assign take_load   = s_valid && s_ready && (s_cmd == CMD_LOAD);
    assign out_load    = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // chain control
    always_comb begin
        ctrl.shift   = take_filter;
        ctrl.rotate  = (state_reg == ST_RUN);
        ctrl.clear_h = (state_reg == ST_RUN) && (cnt_reg == CNT_LAST) && last_reg;
    end

    // head of the chain: new sample on shift, wrap-around on rotate
    always_comb begin
        head = chain[TAPS-1];
        if (!ctrl.rotate) begin
            head.re = s_sample_re;
            head.im = s_sample_im;
        end
    end

    // tap chain, cell j pairs the sample j steps old with coefficient TAPS-1-j
    for (genvar j = 0; j < TAPS; j++) begin : g_cell
        localparam int COEF_IDX = TAPS - 1 - j;
        logic load_en;

        if (COEF_IDX < LOAD_SPAN) begin : g_ld
            assign load_en = take_load && (s_coef_index == IDX_W'(COEF_IDX));
        end else begin : g_nold
            assign load_en = 1'b0;
        end

        cpfir_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .load_en    (load_en),
            .coef_value (s_coef_value),
            .prev       ((j == 0) ? head : chain[(j == 0) ? 0 : j - 1]),
            .cur        (chain[j])
        );
    end

    cpfir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .acc_clr   (take_filter),
        .tap_vld   (ctrl.rotate),
        .tap       (chain[TAPS-1]),
        .result_re (mac_re),
        .result_im (mac_im),
        .saturated (mac_sat)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take_filter) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    last_next  = s_last_of_block;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result item register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_re_reg <= mac_re;
            res_im_reg <= mac_im;
            sat_reg    <= mac_sat;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_result_re = res_re_reg;
    assign m_result_im = res_im_reg;
    assign m_saturated = sat_reg;

endmodule
